>>> rtl/core/qir_pkg.sv
// ----------------------------------------------------------------------------
// qir_pkg
// Shared types and constants for the quaternion inverse rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package qir_pkg;

  localparam int SQ_STAGES = 32;
  localparam int DV_STAGES = 31;

  typedef struct packed {
    logic [63:0]      rem;
    logic [31:0]      root;
    logic [3:0][15:0] mag;
    logic [3:0]       neg;
    logic [2:0][15:0] vec;
    logic             pass;
  } sq_t;

  typedef struct packed {
    logic [3:0][62:0] rem;
    logic [3:0][30:0] quo;
    logic [31:0]      root;
    logic [3:0]       neg;
    logic [2:0][15:0] vec;
    logic             pass;
  } dv_t;

endpackage
`default_nettype wire

>>> rtl/core/quaternion_inverse_rotate_top.sv
// ----------------------------------------------------------------------------
// quaternion_inverse_rotate_top
// Normalizes, conjugates a Q2.14 quaternion; rotates or passes a Q3.12 vector
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// in      | in_valid, in_stall, quat_*, vec_*         | into block
// out     | out_valid, out_stall, rot_*, saturated,   | out of block
//         | passed_through                            |
//
// One item per cycle but for output stalls; 32 root stages (one root bit
// each), 31 divider stages (one quotient bit each), two multiply stages.
// Reset clears the valid bits only.
// A stall on the result side holds the whole pipeline; in_stall follows it.
`default_nettype none
module quaternion_inverse_rotate_top import qir_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] quat_w,
  input  wire signed [15:0] quat_x,
  input  wire signed [15:0] quat_y,
  input  wire signed [15:0] quat_z,
  input  wire signed [15:0] vec_x,
  input  wire signed [15:0] vec_y,
  input  wire signed [15:0] vec_z,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] rot_x,
  output logic signed [15:0] rot_y,
  output logic signed [15:0] rot_z,
  output logic              saturated,
  output logic              passed_through
);

  localparam logic [32:0] LIM =
    33'((64'd1 << (2 * QUAT_FRAC_BITS)) / 64'd1000000000000);

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // square stage
  logic             a_vld;
  logic [3:0][31:0] a_sq;
  logic [3:0][15:0] a_mag;
  logic [3:0]       a_neg;
  logic [2:0][15:0] a_vec;
  logic signed [15:0] qin [4];

  assign qin[0] = quat_w;
  assign qin[1] = quat_x;
  assign qin[2] = quat_y;
  assign qin[3] = quat_z;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        a_sq[k]  <= 32'(qin[k] * qin[k]);
        a_mag[k] <= qin[k][15] ? 16'(-qin[k]) : qin[k];
        a_neg[k] <= qin[k][15];
      end
      a_vec <= {vec_z, vec_y, vec_x};
    end
  end

  // norm stage, square root stages
  logic [32:0] n2;
  assign n2 = 33'(a_sq[0]) + 33'(a_sq[1]) + 33'(a_sq[2]) + 33'(a_sq[3]);

  sq_t  sq    [SQ_STAGES+1];
  logic sq_vld [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].rem  <= {1'b0, n2, 30'd0};
      sq[0].root <= '0;
      sq[0].mag  <= a_mag;
      sq[0].neg  <= a_neg;
      sq[0].vec  <= a_vec;
      sq[0].pass <= (n2 <= LIM);
    end
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    localparam int B = SQ_STAGES - 1 - g;
    logic [65:0] trial;
    sq_t         sq_next;
    assign trial = (66'(sq[g].root) << (B + 1)) + (66'd1 << (2 * B));

    always_comb begin
      sq_next = sq[g];
      if (66'(sq[g].rem) >= trial) begin
        sq_next.rem     = 64'(66'(sq[g].rem) - trial);
        sq_next.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sq_vld[g+1] <= 1'b0;
      else if (en) sq_vld[g+1] <= sq_vld[g];
    end

    always_ff @(posedge clk) begin
      if (en) sq[g+1] <= sq_next;
    end
  end

  // divider stages: |q| * 2^45 / root
  dv_t  dv     [DV_STAGES+1];
  logic dv_vld [DV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (en) dv_vld[0] <= sq_vld[SQ_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dv[0].rem[k] <= {2'b0, sq[SQ_STAGES].mag[k], 45'd0};
        dv[0].quo[k] <= '0;
      end
      dv[0].root <= sq[SQ_STAGES].root;
      dv[0].neg  <= sq[SQ_STAGES].neg;
      dv[0].vec  <= sq[SQ_STAGES].vec;
      dv[0].pass <= sq[SQ_STAGES].pass;
    end
  end

  for (genvar g = 0; g < DV_STAGES; g++) begin : g_div
    localparam int B = DV_STAGES - 1 - g;
    logic [62:0] dsh;
    dv_t         dv_next;
    assign dsh = 63'(dv[g].root) << B;

    always_comb begin
      dv_next = dv[g];
      for (int k = 0; k < 4; k++) begin
        if (dv[g].rem[k] >= dsh) begin
          dv_next.rem[k]    = dv[g].rem[k] - dsh;
          dv_next.quo[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[g+1] <= 1'b0;
      else if (en) dv_vld[g+1] <= dv_vld[g];
    end

    always_ff @(posedge clk) begin
      if (en) dv[g+1] <= dv_next;
    end
  end

  // first products: u x v
  dv_t last;
  assign last = dv[DV_STAGES];

  logic signed [31:0] uc [4];
  always_comb begin
    uc[0] = last.neg[0] ? -$signed({1'b0, last.quo[0]}) : $signed({1'b0, last.quo[0]});
    for (int k = 1; k < 4; k++)
      uc[k] = last.neg[k] ? $signed({1'b0, last.quo[k]}) : -$signed({1'b0, last.quo[k]});
  end

  logic signed [15:0] lv [3];
  assign lv[0] = last.vec[0];
  assign lv[1] = last.vec[1];
  assign lv[2] = last.vec[2];

  logic               m1_vld, m1_pass;
  logic signed [31:0] m1_u [4];
  logic signed [47:0] m1_p [6];
  logic [2:0][15:0]   m1_vec;

  always_ff @(posedge clk) begin
    if (rst) m1_vld <= 1'b0;
    else if (en) m1_vld <= dv_vld[DV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_u   <= uc;
      m1_p[0] <= uc[2] * lv[2];
      m1_p[1] <= uc[3] * lv[1];
      m1_p[2] <= uc[3] * lv[0];
      m1_p[3] <= uc[1] * lv[2];
      m1_p[4] <= uc[1] * lv[1];
      m1_p[5] <= uc[2] * lv[0];
      m1_vec  <= last.vec;
      m1_pass <= last.pass;
    end
  end

  // round u x v
  logic               u2_vld, u2_pass;
  logic signed [31:0] u2_u [4];
  logic signed [31:0] u2_uv [3];
  logic [2:0][15:0]   u2_vec;
  logic signed [48:0] d [3];

  always_comb begin
    for (int k = 0; k < 3; k++)
      d[k] = 49'(m1_p[2*k]) - 49'(m1_p[2*k+1]) + 49'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) u2_vld <= 1'b0;
    else if (en) u2_vld <= m1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_u <= m1_u;
      for (int k = 0; k < 3; k++) u2_uv[k] <= d[k][47:16];
      u2_vec  <= m1_vec;
      u2_pass <= m1_pass;
    end
  end

  // second products: w*uv and u x uv
  logic               m2_vld, m2_pass;
  logic signed [63:0] m2_w [3];
  logic signed [63:0] m2_a [3];
  logic signed [63:0] m2_b [3];
  logic [2:0][15:0]   m2_vec;

  always_ff @(posedge clk) begin
    if (rst) m2_vld <= 1'b0;
    else if (en) m2_vld <= u2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) m2_w[k] <= u2_u[0] * u2_uv[k];
      m2_a[0] <= u2_u[2] * u2_uv[2];
      m2_b[0] <= u2_u[3] * u2_uv[1];
      m2_a[1] <= u2_u[3] * u2_uv[0];
      m2_b[1] <= u2_u[1] * u2_uv[2];
      m2_a[2] <= u2_u[1] * u2_uv[1];
      m2_b[2] <= u2_u[2] * u2_uv[0];
      m2_vec  <= u2_vec;
      m2_pass <= u2_pass;
    end
  end

  // sum, round, add, saturate
  logic signed [66:0] acc [3];
  logic signed [66:0] rs  [3];
  logic signed [23:0] r   [3];
  logic signed [15:0] rc  [3];
  logic [2:0]         sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = (67'(m2_w[k]) + 67'(m2_a[k]) - 67'(m2_b[k])) <<< 1;
      rs[k]  = (acc[k] + (67'sd1 <<< 43)) >>> 44;
      r[k]   = $signed(24'($signed(m2_vec[k]))) + rs[k][23:0];
      sat[k] = 1'b0;
      rc[k]  = r[k][15:0];
      if (r[k] > 24'sd32767) begin
        rc[k] = 16'sh7fff; sat[k] = 1'b1;
      end else if (r[k] < -24'sd32768) begin
        rc[k] = 16'sh8000; sat[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= m2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (m2_pass) begin
        rot_x <= m2_vec[0];
        rot_y <= m2_vec[1];
        rot_z <= m2_vec[2];
        saturated <= 1'b0;
      end else begin
        rot_x <= rc[0];
        rot_y <= rc[1];
        rot_z <= rc[2];
        saturated <= |sat;
      end
      passed_through <= m2_pass;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/qir_checker.sv
// ----------------------------------------------------------------------------
// qir_checker
// Port-level checks for the quaternion inverse rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module qir_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] rot_x,
  input wire        saturated,
  input wire        passed_through
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rot_x))
    else $error("stalled transfer changed");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(saturated && passed_through))
    else $error("saturated with pass-through");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind quaternion_inverse_rotate_top qir_checker u_qir_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .rot_x(rot_x),
  .saturated(saturated), .passed_through(passed_through)
);
`default_nettype wire
